@@ design/mti_pkg.sv @@
package mti_pkg;

  // Network shape and number format.
  localparam int IN_CNT  = 784;
  localparam int HID_CNT = 128;
  localparam int OUT_CNT = 10;
  localparam int DATA_W  = 16;
  localparam int FRAC    = 12;

  // Fixed field widths of the ports.
  localparam int OPC_W   = 3;
  localparam int ADDR_W  = 17;
  localparam int CLASS_W = 4;
  localparam int SCORE_W = 16;

  function automatic int cw(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  localparam int HW_DEPTH = IN_CNT * HID_CNT;
  localparam int OW_DEPTH = HID_CNT * OUT_CNT;
  localparam int HW_AW    = cw(HW_DEPTH);
  localparam int OW_AW    = cw(OW_DEPTH);
  localparam int HB_AW    = cw(HID_CNT);
  localparam int OB_AW    = cw(OUT_CNT);
  localparam int PX_AW    = cw(IN_CNT);
  localparam int WA_W     = cw((HW_DEPTH > OW_DEPTH) ? HW_DEPTH : OW_DEPTH);
  localparam int IDX_W    = cw((IN_CNT > HID_CNT) ? IN_CNT : HID_CNT);
  localparam int NEU_W    = cw((HID_CNT > OUT_CNT) ? HID_CNT : OUT_CNT);
  localparam int ACC_W    = 2 * DATA_W + IDX_W + 2;

  // Sigmoid table and its generator.
  localparam int SIG_DEPTH = 256;
  localparam int SIG_AW    = 8;
  localparam int SIG_HALF  = 128;
  localparam int P_W       = 33;
  localparam int DEN_W     = 34;
  localparam int DIV_W     = 50;
  localparam int REM_W     = 35;
  localparam logic [31:0] SIG_E = 32'd4034748382;

  typedef enum logic [OPC_W-1:0] {
    OP_HW  = 3'd0,
    OP_OW  = 3'd1,
    OP_HB  = 3'd2,
    OP_OB  = 3'd3,
    OP_PX  = 3'd4,
    OP_RUN = 3'd5,
    OP_NOP6 = 3'd6,
    OP_NOP7 = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_HMAC,
    ST_HDRAIN,
    ST_HFIN,
    ST_OMAC,
    ST_ODRAIN,
    ST_OFIN,
    ST_OSIG
  } state_t;

  typedef enum logic [2:0] {
    SG_HI,
    SG_LO,
    SG_DIV,
    SG_MUL0,
    SG_MUL1,
    SG_DONE
  } sg_state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

  typedef struct packed {
    logic               we;
    logic [SIG_AW-1:0]  addr;
    logic [SCORE_W-1:0] data;
  } sig_wr_t;

  // Arithmetic shift right by FRAC (floor) and saturation to DATA_W bits.
  function automatic logic signed [DATA_W-1:0] sat_shift(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    logic [ACC_W-DATA_W:0]   top;
    s   = v >>> FRAC;
    top = s[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return s[DATA_W-1:0];
    end else if (s[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ design/mti_ram.sv @@
module mti_ram import mti_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = cw(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/mti_mac.sv @@
module mti_mac import mti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] wgt,
  input  logic signed [DATA_W-1:0] dat,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     busy
);

  logic                       v1_r, v2_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  // Stage one: memory data arrives. Stage two: product is added.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= wgt * dat;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = v1_r | v2_r;

endmodule

@@ design/mti_sig_gen.sv @@
module mti_sig_gen import mti_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  output sig_wr_t wr,
  output logic    done
);

  sg_state_t           st_r, st_nxt;
  logic [SIG_AW:0]     k_r, k_nxt;
  logic [P_W-1:0]      p_r, p_nxt;
  logic                lo_r, lo_nxt;
  logic [DIV_W-1:0]    n_r, n_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [SCORE_W-1:0]  q_r, q_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [48:0]         plo_r, plo_nxt;

  logic [REM_W-1:0]    trial;
  logic                ge;
  logic [DEN_W-1:0]    den_c;
  logic [48:0]         phi;
  logic [64:0]         psum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SG_HI;
      k_r  <= '0;
      p_r  <= {1'b1, 32'd0};
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
      p_r  <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    plo_r <= plo_nxt;
  end

  always_comb begin
    trial = {rem_r[REM_W-2:0], n_r[DIV_W-1]};
    ge    = trial >= REM_W'(den_r);
    den_c = DEN_W'(p_r) + {2'b01, 32'd0};
    phi   = 49'(p_r) * 49'(SIG_E[31:16]);
    psum  = 65'(plo_r) + (65'(phi) << 16) + {33'd0, 1'b1, 31'd0};

    st_nxt  = st_r;
    k_nxt   = k_r;
    p_nxt   = p_r;
    lo_nxt  = lo_r;
    n_nxt   = n_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    plo_nxt = plo_r;
    wr      = '0;

    unique case (st_r)
      SG_HI: begin
        // Upper half: 65535 / (1 + exp(-k/16)), rounded.
        if (k_r < (SIG_AW+1)'(SIG_HALF)) begin
          den_nxt = den_c;
          n_nxt   = {2'd0, 16'hFFFF, 32'd0} + DIV_W'(den_c >> 1);
          rem_nxt = '0;
          cnt_nxt = '0;
          lo_nxt  = 1'b0;
          st_nxt  = SG_DIV;
        end else begin
          st_nxt = SG_LO;
        end
      end
      SG_LO: begin
        // Lower half: 65535 * exp(-k/16) / (1 + exp(-k/16)), rounded.
        if (k_r != '0) begin
          den_nxt = den_c;
          n_nxt   = (DIV_W'(p_r) << 16) - DIV_W'(p_r) + DIV_W'(den_c >> 1);
          rem_nxt = '0;
          cnt_nxt = '0;
          lo_nxt  = 1'b1;
          st_nxt  = SG_DIV;
        end else begin
          st_nxt = SG_MUL0;
        end
      end
      SG_DIV: begin
        rem_nxt = ge ? (trial - REM_W'(den_r)) : trial;
        n_nxt   = n_r << 1;
        q_nxt   = {q_r[SCORE_W-2:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          wr.we   = 1'b1;
          wr.addr = lo_r ? SIG_AW'((SIG_AW+1)'(SIG_HALF) - k_r)
                         : SIG_AW'((SIG_AW+1)'(SIG_HALF) + k_r);
          wr.data = {q_r[SCORE_W-2:0], ge};
          if (!lo_r) begin
            st_nxt = SG_LO;
          end else if (k_r == (SIG_AW+1)'(SIG_HALF)) begin
            st_nxt = SG_DONE;
          end else begin
            st_nxt = SG_MUL0;
          end
        end
      end
      SG_MUL0: begin
        plo_nxt = 49'(p_r) * 49'(SIG_E[15:0]);
        st_nxt  = SG_MUL1;
      end
      SG_MUL1: begin
        p_nxt  = psum[64:32];
        k_nxt  = k_r + (SIG_AW+1)'(1);
        st_nxt = SG_HI;
      end
      SG_DONE: begin
        st_nxt = SG_DONE;
      end
      default: begin
        st_nxt = SG_HI;
      end
    endcase
  end

  assign done = (st_r == SG_DONE);

endmodule

@@ design/mlp_two_layer_inference.sv @@
// Two-layer 784-128-10 fully connected inference engine in signed Q4.12.
// Items are issued with start while busy is low, one beat per item. Load
// beats (hidden weight, output weight, hidden bias, output bias, pixel) are
// accepted one per cycle and produce nothing; a load whose address is past
// the end of its store, and the two unused opcodes, are dropped. A run beat
// holds busy high while the engine walks every weight once through a single
// multiply-accumulate unit fed by one read port on each store: each hidden
// neuron passes through issue, drain and finish states, and each output
// neuron also through a sigmoid lookup state. The ten results leave as
// single-cycle out_valid pulses, one per output neuron in class order, with
// out_last_result set on the tenth. The receiver cannot stall, so it must
// take every result in the cycle it is shown. After reset the block zeroes
// the weight, bias and pixel stores one entry per cycle, a pass whose length
// is set by the hidden weight store, while it builds its sigmoid table with
// a serial divider alongside; busy stays high until both are finished and
// the first beat can be accepted. Entries that were never loaded therefore
// read as zero.
module mlp_two_layer_inference import mti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OPC_W-1:0]          in_opcode,
  input  logic [ADDR_W-1:0]         in_address,
  input  logic signed [DATA_W-1:0]  in_value,
  output logic                      out_valid,
  output logic [CLASS_W-1:0]        out_class_index,
  output logic signed [DATA_W-1:0]  out_logit,
  output logic [SCORE_W-1:0]        out_score,
  output logic                      out_last_result
);

  state_t                   state_r, state_nxt;
  logic [NEU_W-1:0]         n_r, n_nxt;
  logic [IDX_W-1:0]         i_r, i_nxt;
  logic [WA_W-1:0]          wa_r, wa_nxt;
  logic signed [DATA_W-1:0] logit_r, logit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]       out_class_r, out_class_nxt;
  logic signed [DATA_W-1:0] out_logit_r, out_logit_nxt;
  logic [SCORE_W-1:0]       out_score_r, out_score_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [WA_W-1:0]          clr_r, clr_nxt;
  logic                     clr_done_r, clr_done_nxt;

  opcode_t                  op;
  logic                     load;
  logic                     clr_we;
  logic [ADDR_W-1:0]        wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic                     hw_we, ow_we, hb_we, ob_we, px_we, ha_we;
  logic [DATA_W-1:0]        hw_rd, ow_rd, hb_rd, ob_rd, px_rd, ha_rd;
  logic [SCORE_W-1:0]       sig_rd;
  logic [SIG_AW-1:0]        sig_raddr;
  sig_wr_t                  sig_wr;
  logic                     sg_done;

  mac_ctl_t                 ctl;
  logic signed [DATA_W-1:0] mac_wgt, mac_dat;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     mac_busy;
  logic                     hid_phase;
  logic signed [ACC_W-1:0]  acc_tot, acc_relu;
  logic signed [DATA_W-1:0] act_c, logit_c, lidx;

  // The clearing pass owns the write ports while it runs; busy keeps loads
  // out during that time.
  assign clr_we  = (state_r == ST_INIT) && !clr_done_r;
  assign wr_addr = clr_we ? ADDR_W'(clr_r) : in_address;
  assign wr_data = clr_we ? '0 : in_value;

  // Load decode: a beat writes its store only when the address is in range.
  assign op    = opcode_t'(in_opcode);
  assign load  = start && !busy;
  assign hw_we = (clr_we && (32'(clr_r) < 32'(HW_DEPTH))) ||
                 (load && (op == OP_HW) && (32'(in_address) < 32'(HW_DEPTH)));
  assign ow_we = (clr_we && (32'(clr_r) < 32'(OW_DEPTH))) ||
                 (load && (op == OP_OW) && (32'(in_address) < 32'(OW_DEPTH)));
  assign hb_we = (clr_we && (32'(clr_r) < 32'(HID_CNT))) ||
                 (load && (op == OP_HB) && (32'(in_address) < 32'(HID_CNT)));
  assign ob_we = (clr_we && (32'(clr_r) < 32'(OUT_CNT))) ||
                 (load && (op == OP_OB) && (32'(in_address) < 32'(OUT_CNT)));
  assign px_we = (clr_we && (32'(clr_r) < 32'(IN_CNT))) ||
                 (load && (op == OP_PX) && (32'(in_address) < 32'(IN_CNT)));

  mti_ram #(.WIDTH(DATA_W), .DEPTH(HW_DEPTH)) u_hw_ram (
    .clk(clk), .we(hw_we), .waddr(HW_AW'(wr_addr)), .wdata(wr_data),
    .raddr(HW_AW'(wa_r)), .rdata(hw_rd)
  );

  mti_ram #(.WIDTH(DATA_W), .DEPTH(OW_DEPTH)) u_ow_ram (
    .clk(clk), .we(ow_we), .waddr(OW_AW'(wr_addr)), .wdata(wr_data),
    .raddr(OW_AW'(wa_r)), .rdata(ow_rd)
  );

  mti_ram #(.WIDTH(DATA_W), .DEPTH(HID_CNT)) u_hb_ram (
    .clk(clk), .we(hb_we), .waddr(HB_AW'(wr_addr)), .wdata(wr_data),
    .raddr(HB_AW'(n_r)), .rdata(hb_rd)
  );

  mti_ram #(.WIDTH(DATA_W), .DEPTH(OUT_CNT)) u_ob_ram (
    .clk(clk), .we(ob_we), .waddr(OB_AW'(wr_addr)), .wdata(wr_data),
    .raddr(OB_AW'(n_r)), .rdata(ob_rd)
  );

  mti_ram #(.WIDTH(DATA_W), .DEPTH(IN_CNT)) u_px_ram (
    .clk(clk), .we(px_we), .waddr(PX_AW'(wr_addr)), .wdata(wr_data),
    .raddr(PX_AW'(i_r)), .rdata(px_rd)
  );

  // Hidden activations: written at the end of each hidden neuron, read by
  // the output layer.
  mti_ram #(.WIDTH(DATA_W), .DEPTH(HID_CNT)) u_ha_ram (
    .clk(clk), .we(ha_we), .waddr(HB_AW'(n_r)), .wdata(act_c),
    .raddr(HB_AW'(i_r)), .rdata(ha_rd)
  );

  // Sigmoid table, filled once after reset by the generator.
  mti_ram #(.WIDTH(SCORE_W), .DEPTH(SIG_DEPTH)) u_sig_ram (
    .clk(clk), .we(sig_wr.we), .waddr(sig_wr.addr), .wdata(sig_wr.data),
    .raddr(sig_raddr), .rdata(sig_rd)
  );

  mti_sig_gen u_sig_gen (
    .clk(clk), .rst_n(rst_n), .wr(sig_wr), .done(sg_done)
  );

  // The hidden and output layers share one multiply-accumulate unit.
  assign hid_phase = (state_r == ST_HMAC) || (state_r == ST_HDRAIN) || (state_r == ST_HFIN);
  assign mac_wgt   = hid_phase ? signed'(hw_rd) : signed'(ow_rd);
  assign mac_dat   = hid_phase ? signed'(px_rd) : signed'(ha_rd);

  mti_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .wgt(mac_wgt), .dat(mac_dat),
    .acc(mac_acc), .busy(mac_busy)
  );

  // Finish a neuron: add the bias aligned to Q20.24, then ReLU for the
  // hidden layer, then floor shift and saturate.
  always_comb begin
    acc_tot  = mac_acc + (ACC_W'(signed'(hid_phase ? hb_rd : ob_rd)) <<< FRAC);
    acc_relu = acc_tot[ACC_W-1] ? '0 : acc_tot;
    act_c    = sat_shift(acc_relu);
    logit_c  = sat_shift(acc_tot);
    lidx     = logit_c >>> 8;
    if (lidx < -DATA_W'(SIG_HALF)) begin
      sig_raddr = '0;
    end else if (lidx > DATA_W'(SIG_HALF - 1)) begin
      sig_raddr = '1;
    end else begin
      sig_raddr = SIG_AW'(lidx + DATA_W'(SIG_HALF));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      clr_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      clr_done_r  <= clr_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    wa_r        <= wa_nxt;
    logit_r     <= logit_nxt;
    out_class_r <= out_class_nxt;
    out_logit_r <= out_logit_nxt;
    out_score_r <= out_score_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    wa_nxt        = wa_r;
    logit_nxt     = logit_r;
    out_valid_nxt = 1'b0;
    out_class_nxt = out_class_r;
    out_logit_nxt = out_logit_r;
    out_score_nxt = out_score_r;
    out_last_nxt  = out_last_r;
    clr_nxt       = clr_r;
    clr_done_nxt  = clr_done_r;
    ctl           = '0;
    ha_we         = 1'b0;

    // The clearing pass walks the largest store once.
    if (clr_we) begin
      if (clr_r == WA_W'(HW_DEPTH - 1)) begin
        clr_done_nxt = 1'b1;
      end else begin
        clr_nxt = clr_r + WA_W'(1);
      end
    end

    unique case (state_r)
      ST_INIT: begin
        if (sg_done && clr_done_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && (op == OP_RUN)) begin
          ctl.clear = 1'b1;
          n_nxt     = '0;
          i_nxt     = '0;
          wa_nxt    = '0;
          state_nxt = ST_HMAC;
        end
      end
      ST_HMAC: begin
        // Weight address walks input * HID_CNT + neuron.
        ctl.issue = 1'b1;
        i_nxt     = i_r + IDX_W'(1);
        wa_nxt    = wa_r + WA_W'(HID_CNT);
        if (i_r == IDX_W'(IN_CNT - 1)) begin
          state_nxt = ST_HDRAIN;
        end
      end
      ST_HDRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_HFIN;
        end
      end
      ST_HFIN: begin
        ha_we     = 1'b1;
        ctl.clear = 1'b1;
        i_nxt     = '0;
        if (n_r == NEU_W'(HID_CNT - 1)) begin
          n_nxt     = '0;
          wa_nxt    = '0;
          state_nxt = ST_OMAC;
        end else begin
          n_nxt     = n_r + NEU_W'(1);
          wa_nxt    = WA_W'(n_r) + WA_W'(1);
          state_nxt = ST_HMAC;
        end
      end
      ST_OMAC: begin
        // Weight address walks hidden * OUT_CNT + class.
        ctl.issue = 1'b1;
        i_nxt     = i_r + IDX_W'(1);
        wa_nxt    = wa_r + WA_W'(OUT_CNT);
        if (i_r == IDX_W'(HID_CNT - 1)) begin
          state_nxt = ST_ODRAIN;
        end
      end
      ST_ODRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_OFIN;
        end
      end
      ST_OFIN: begin
        // The table read address comes from the logit in this cycle.
        logit_nxt = logit_c;
        ctl.clear = 1'b1;
        state_nxt = ST_OSIG;
      end
      ST_OSIG: begin
        out_valid_nxt = 1'b1;
        out_class_nxt = CLASS_W'(n_r);
        out_logit_nxt = logit_r;
        out_score_nxt = sig_rd;
        out_last_nxt  = (n_r == NEU_W'(OUT_CNT - 1));
        i_nxt         = '0;
        if (n_r == NEU_W'(OUT_CNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          n_nxt     = n_r + NEU_W'(1);
          wa_nxt    = WA_W'(n_r) + WA_W'(1);
          state_nxt = ST_OMAC;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_class_index = out_class_r;
  assign out_logit       = out_logit_r;
  assign out_score       = out_score_r;
  assign out_last_result = out_last_r;

endmodule
